// ===== rtl/rc4_pkg.sv =====
// Package for the RC4 stream cipher core.
// Holds the byte type, the item kinds and the S-box memory request struct shared by the core
// and its RAM. No dependencies.
package rc4_pkg;

	typedef logic [7:0] byte_t;

	// Item kinds carried on the command field.
	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	// One cycle's access to the S-box memory: one write port and one read port.
	typedef struct packed {
		logic  we;
		byte_t waddr;
		byte_t wdata;
		logic  re;
		byte_t raddr;
	} sbox_req_t;

endpackage

// ===== rtl/rc4_stream_cipher_core.sv =====
// Top level of the RC4 stream cipher core: sequencer, shared byte adder and output register.
// Depends on rc4_pkg, rc4_key_store and rc4_sbox_ram.
//
// Channel   Dir  Signals          Item contents
// s_axis    in   tdata[15:0]      key_byte [7:0], data_byte [15:8]
//                tuser            command (0 = key byte, 1 = data byte)
//                tlast            key_last
// m_axis    out  tdata[7:0]       out_byte
//
// A key byte is written to the key store as it is accepted, while the store has room.
// A key byte with tlast starts the key schedule: identity fill of all 256 S-box entries,
// then one mixing round per S-box entry (four S-box accesses per round), during which no item is taken.
// A data byte passes through the accept step, four S-box steps (five accesses, the last
// write and read sharing a cycle) and the output step.
// The next item is accepted while a result waits in the output register; a stalled
// output holds the sequencer in its last step. Reset is asynchronous and active low.
module rc4_stream_cipher_core #(
	parameter int KEY_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // key_byte [7:0], data_byte [15:8]
	input  logic        s_axis_tuser,  // command
	input  logic        s_axis_tlast,  // key_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // out_byte
);
	import rc4_pkg::*;

	localparam int CNT_W  = $clog2(KEY_DEPTH + 1);
	localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_INIT    = 4'd1;
	localparam logic [3:0] ST_KS_RD_N = 4'd2;
	localparam logic [3:0] ST_KS_RD_A = 4'd3;
	localparam logic [3:0] ST_KS_WR_N = 4'd4;
	localparam logic [3:0] ST_KS_WR_A = 4'd5;
	localparam logic [3:0] ST_DG_RD_I = 4'd6;
	localparam logic [3:0] ST_DG_RD_J = 4'd7;
	localparam logic [3:0] ST_DG_WR_I = 4'd8;
	localparam logic [3:0] ST_DG_WR_J = 4'd9;
	localparam logic [3:0] ST_DG_OUT  = 4'd10;

	logic [3:0]       state_q;
	byte_t            n_q;
	byte_t            acc_q;
	byte_t            i_q;
	byte_t            j_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KIDX_W-1:0] kidx_q;
	logic             out_valid_q;

	byte_t            data_q;
	byte_t            si_q;
	byte_t            sj_q;
	byte_t            out_q;
	logic             fwd_q;

	sbox_req_t        sbox_req;
	byte_t            sbox_rd;
	byte_t            key_rd;
	byte_t            add_a;
	byte_t            add_b;
	byte_t            add_c;
	byte_t            sum;
	logic             accept;
	logic             key_wr;
	logic             kidx_wrap;
	logic             out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign key_wr        = accept && (s_axis_tuser == CMD_KEY) && (cnt_q < CNT_W'(KEY_DEPTH));
	assign kidx_wrap     = ((CNT_W'(kidx_q) + CNT_W'(1)) == cnt_q);
	assign out_free      = !out_valid_q || m_axis_tready;

	rc4_key_store #(
		.DEPTH (KEY_DEPTH),
		.IDX_W (KIDX_W)
	) u_key_store (
		.clk   (clk),
		.we    (key_wr),
		.waddr (cnt_q[KIDX_W-1:0]),
		.wdata (s_axis_tdata[7:0]),
		.re    (state_q == ST_KS_RD_N),
		.raddr (kidx_q),
		.rdata (key_rd)
	);

	rc4_sbox_ram u_sbox (
		.clk   (clk),
		.req   (sbox_req),
		.rdata (sbox_rd)
	);

	// Shared byte adder: its operands are chosen by the current step.
	always_comb begin
		add_a = n_q;
		add_b = 8'd1;
		add_c = 8'd0;
		unique case (state_q)
			ST_IDLE: begin
				add_a = i_q;
			end
			ST_KS_RD_A: begin
				add_a = acc_q;
				add_b = sbox_rd;
				add_c = key_rd;
			end
			ST_DG_RD_J: begin
				add_a = j_q;
				add_b = sbox_rd;
			end
			ST_DG_WR_J: begin
				add_a = si_q;
				add_b = sj_q;
			end
			default: begin
				add_a = n_q;
			end
		endcase
		sum = add_a + add_b + add_c;
	end

	// S-box port: one access pattern for each step of the sequencer.
	always_comb begin
		sbox_req = '0;
		unique case (state_q)
			ST_INIT: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = n_q;
				sbox_req.wdata = n_q;
			end
			ST_KS_RD_N: begin
				sbox_req.re    = 1'b1;
				sbox_req.raddr = n_q;
			end
			ST_KS_RD_A: begin
				sbox_req.re    = 1'b1;
				sbox_req.raddr = sum;
			end
			ST_KS_WR_N: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = n_q;
				sbox_req.wdata = sbox_rd;
			end
			ST_KS_WR_A: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = acc_q;
				sbox_req.wdata = si_q;
			end
			ST_DG_RD_I: begin
				sbox_req.re    = 1'b1;
				sbox_req.raddr = i_q;
			end
			ST_DG_RD_J: begin
				sbox_req.re    = 1'b1;
				sbox_req.raddr = sum;
			end
			ST_DG_WR_I: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = i_q;
				sbox_req.wdata = sbox_rd;
			end
			ST_DG_WR_J: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = j_q;
				sbox_req.wdata = si_q;
				sbox_req.re    = 1'b1;
				sbox_req.raddr = sum;
			end
			default: begin
				sbox_req = '0;
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			acc_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			kidx_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser == CMD_DATA) begin
							i_q     <= sum;
							state_q <= ST_DG_RD_I;
						end else begin
							if (key_wr) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
							if (s_axis_tlast) begin
								n_q     <= '0;
								acc_q   <= '0;
								kidx_q  <= '0;
								state_q <= ST_INIT;
							end
						end
					end
				end
				ST_INIT: begin
					n_q <= sum;
					if (n_q == 8'hFF) begin
						state_q <= ST_KS_RD_N;
					end
				end
				ST_KS_RD_N: begin
					state_q <= ST_KS_RD_A;
				end
				ST_KS_RD_A: begin
					acc_q   <= sum;
					state_q <= ST_KS_WR_N;
				end
				ST_KS_WR_N: begin
					state_q <= ST_KS_WR_A;
				end
				ST_KS_WR_A: begin
					n_q    <= sum;
					kidx_q <= kidx_wrap ? '0 : kidx_q + KIDX_W'(1);
					if (n_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_KS_RD_N;
					end
				end
				ST_DG_RD_I: begin
					state_q <= ST_DG_RD_J;
				end
				ST_DG_RD_J: begin
					j_q     <= sum;
					state_q <= ST_DG_WR_I;
				end
				ST_DG_WR_I: begin
					state_q <= ST_DG_WR_J;
				end
				ST_DG_WR_J: begin
					state_q <= ST_DG_OUT;
				end
				ST_DG_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output valid flag: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DG_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tvalid && m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers: captured S-box bytes, the data byte and the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= s_axis_tdata[15:8];
		end
		if (state_q == ST_KS_RD_A || state_q == ST_DG_RD_J) begin
			si_q <= sbox_rd;
		end
		if (state_q == ST_DG_WR_I) begin
			sj_q <= sbox_rd;
		end
		// The read of S[t] misses the write to S[j] in the same cycle, so that case is forwarded.
		if (state_q == ST_DG_WR_J) begin
			fwd_q <= (sum == j_q);
		end
		if (state_q == ST_DG_OUT && out_free) begin
			out_q <= data_q ^ (fwd_q ? si_q : sbox_rd);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
	// The stored key length never exceeds the key store.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(KEY_DEPTH))
		else $error("key count beyond key store depth");

	// The cyclic key index stays inside the stored key during mixing.
	a_kidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KS_RD_N) |-> (CNT_W'(kidx_q) < cnt_q))
		else $error("key index outside stored key");

	// The last mixing round clears both indices and the key count.
	a_sched_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KS_WR_A && n_q == 8'hFF) |=>
		(i_q == 8'd0 && j_q == 8'd0 && cnt_q == '0 && state_q == ST_IDLE))
		else $error("key schedule did not finish cleanly");

	// A result is never overwritten while it still waits on the output.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result lost");

	// A data item only starts from idle with its index stepped by one.
	a_data_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser == CMD_DATA) |=>
		(state_q == ST_DG_RD_I && i_q == $past(i_q) + 8'd1))
		else $error("data item started wrongly");
`endif

endmodule

// ===== rtl/rc4_sbox_ram.sv =====
// S-box memory of the RC4 core: 256 bytes, one write and one registered read per cycle.
// Depends on rc4_pkg.
module rc4_sbox_ram (
	input  logic              clk,
	input  rc4_pkg::sbox_req_t req,
	output rc4_pkg::byte_t    rdata
);
	import rc4_pkg::*;

	byte_t mem [256];
	byte_t rdata_q;

	// A read in the same cycle as a write to the same entry returns the old byte.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rc4_key_store.sv =====
// Key byte store of the RC4 core, one write and one registered read per cycle.
// Depends on rc4_pkg.
module rc4_key_store #(
	parameter int DEPTH = 256,
	parameter int IDX_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  rc4_pkg::byte_t    wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output rc4_pkg::byte_t    rdata
);
	import rc4_pkg::*;

	byte_t mem [DEPTH];
	byte_t rdata_q;

	// Key bytes are written as key items arrive and read back during the schedule.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== test/rc4_stream_cipher_core_tb.sv =====
// Self-checking testbench for rc4_stream_cipher_core: a directed table, then random keys and data.
// Each output item is checked against an in-bench RC4 generator fed with every accepted item,
// or against its want byte on a checked directed row. Depends on rc4_pkg and the core RTL.
module rc4_stream_cipher_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rc4_pkg::*;

	localparam int KEY_DEPTH = 256;
	localparam int RAND_ITEMS = 950;
	localparam int CYCLE_LIMIT = 1000000;
	// Long enough for a key schedule started by the last item to finish.
	localparam int DRAIN_CYCLES = 1400;

	// One directed item; want is used only where checked is set.
	typedef struct packed {
		logic  cmd;
		byte_t kbyte;
		logic  last;
		byte_t dbyte;
		logic  checked;
		byte_t want;
	} row_t;

	// The first three key bytes are followed by the well-known "Key" / "Plaintext" vector.
	localparam row_t DIR_ROWS [23] = '{
		'{CMD_KEY,  8'h4B, 1'b0, 8'h00, 1'b0, 8'h00},
		'{CMD_KEY,  8'h65, 1'b0, 8'hFF, 1'b0, 8'h00},
		'{CMD_KEY,  8'h79, 1'b1, 8'h00, 1'b0, 8'h00},
		'{CMD_DATA, 8'h00, 1'b0, 8'h50, 1'b1, 8'hBB},
		'{CMD_DATA, 8'h00, 1'b0, 8'h6C, 1'b1, 8'hF3},
		'{CMD_DATA, 8'h00, 1'b0, 8'h61, 1'b1, 8'h16},
		'{CMD_DATA, 8'hFF, 1'b1, 8'h69, 1'b1, 8'hE8},
		'{CMD_DATA, 8'h00, 1'b0, 8'h6E, 1'b1, 8'hD9},
		'{CMD_DATA, 8'h00, 1'b0, 8'h74, 1'b1, 8'h40},
		'{CMD_DATA, 8'h00, 1'b0, 8'h65, 1'b1, 8'hAF},
		'{CMD_DATA, 8'h00, 1'b0, 8'h78, 1'b1, 8'h0A},
		'{CMD_DATA, 8'h00, 1'b0, 8'h74, 1'b1, 8'hD3},
		'{CMD_KEY,  8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
		'{CMD_KEY,  8'hFF, 1'b1, 8'h00, 1'b0, 8'h00},
		'{CMD_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
		'{CMD_DATA, 8'hFF, 1'b0, 8'hFF, 1'b0, 8'h00},
		'{CMD_DATA, 8'h00, 1'b1, 8'h5A, 1'b0, 8'h00},
		'{CMD_KEY,  8'hAA, 1'b0, 8'h00, 1'b0, 8'h00},
		'{CMD_DATA, 8'h00, 1'b0, 8'h55, 1'b0, 8'h00},
		'{CMD_KEY,  8'h01, 1'b1, 8'h00, 1'b0, 8'h00},
		'{CMD_DATA, 8'h00, 1'b0, 8'hFF, 1'b0, 8'h00},
		'{CMD_KEY,  8'hFF, 1'b1, 8'hFF, 1'b0, 8'h00},
		'{CMD_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // key_byte [7:0], data_byte [15:8]
	logic        s_axis_tuser;  // command
	logic        s_axis_tlast;  // key_last
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // out_byte

	// Generator state mirrored in the bench.
	byte_t perm [256];
	byte_t key_mem [KEY_DEPTH];
	int unsigned key_len;
	byte_t gen_i;
	byte_t gen_j;

	byte_t pending_out [$];
	int unsigned items_sent;
	int unsigned bytes_seen;
	int unsigned fails;
	int unsigned cycles;

	rc4_stream_cipher_core #(
		.KEY_DEPTH(KEY_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Store a key byte; on the final one run the key schedule over the bytes kept.
	function automatic void rc4_absorb_key(input byte_t kb, input logic last);
		int unsigned n;
		int unsigned len;
		byte_t acc;
		byte_t tmp;
		if (key_len < KEY_DEPTH) begin
			key_mem[key_len] = kb;
			key_len = key_len + 1;
		end
		if (last) begin
			len = (key_len == 0) ? 1 : key_len;
			for (n = 0; n < 256; n++)
				perm[n] = byte_t'(n);
			acc = 8'h00;
			for (n = 0; n < 256; n++) begin
				acc = acc + perm[n] + key_mem[n % len];
				tmp = perm[n];
				perm[n] = perm[acc];
				perm[acc] = tmp;
			end
			gen_i = 8'h00;
			gen_j = 8'h00;
			key_len = 0;
		end
	endfunction

	// Step the generator once and return the byte XOR the keystream byte.
	function automatic byte_t rc4_crypt_byte(input byte_t db);
		byte_t tmp;
		byte_t t;
		gen_i = gen_i + 8'd1;
		gen_j = gen_j + perm[gen_i];
		tmp = perm[gen_i];
		perm[gen_i] = perm[gen_j];
		perm[gen_j] = tmp;
		t = perm[gen_i] + perm[gen_j];
		return db ^ perm[t];
	endfunction

	// Offer one item after a gap, random or none, and log what it should produce once taken.
	task automatic offer_item(input logic cmd, input byte_t kb, input logic last,
			input byte_t db, input logic checked, input byte_t want);
		int unsigned gap;
		byte_t predicted;
		gap = ((items_sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {db, kb};
		s_axis_tuser <= cmd;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent = items_sent + 1;
		if (cmd == CMD_KEY) begin
			rc4_absorb_key(kb, last);
		end else begin
			predicted = rc4_crypt_byte(db);
			pending_out.push_back(checked ? want : predicted);
		end
	endtask

	// Receiver: random stalls, calm stretches and two long hold-offs to back the core up.
	initial begin
		int unsigned stall;
		byte_t want;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = ((bytes_seen / 64) % 3 == 2) ? 0 : $urandom_range(0, 9);
			if (bytes_seen == 40 || bytes_seen == 500)
				stall = 600;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			bytes_seen = bytes_seen + 1;
			if (pending_out.size() == 0) begin
				$display("%0t: out_byte with none expected: expected none, actual %h",
					$time, m_axis_tdata);
				fails = fails + 1;
			end else begin
				want = pending_out.pop_front();
				if (m_axis_tdata !== want) begin
					$display("%0t: out_byte mismatch: expected %h, actual %h",
						$time, want, m_axis_tdata);
					fails = fails + 1;
				end
			end
		end
	end

	// Stimulus: reset, directed table, then random keys and data runs.
	initial begin
		int unsigned r;
		int unsigned seq;
		int unsigned kind;
		int unsigned klen;
		int unsigned ndata;
		int unsigned k;
		int unsigned d;
		row_t row;
		items_sent = 0;
		bytes_seen = 0;
		fails = 0;
		key_len = 0;
		gen_i = 8'h00;
		gen_j = 8'h00;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 16'h0000;
		s_axis_tuser <= CMD_KEY;
		s_axis_tlast <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(DIR_ROWS); r++) begin
			row = DIR_ROWS[r];
			offer_item(row.cmd, row.kbyte, row.last, row.dbyte, row.checked, row.want);
		end

		// The first random key fills and may overrun the key store; some keys are one byte
		// long and some are broken by data items, which keep using the previous generator.
		seq = 0;
		while (items_sent < RAND_ITEMS + $size(DIR_ROWS)) begin
			kind = $urandom_range(0, 9);
			if (seq == 0)
				klen = KEY_DEPTH + $urandom_range(0, 4);
			else if (kind == 0)
				klen = 1;
			else
				klen = $urandom_range(2, 16);
			for (k = 0; k < klen; k++) begin
				if (kind == 1 && k == klen / 2) begin
					ndata = $urandom_range(1, 4);
					for (d = 0; d < ndata; d++)
						offer_item(CMD_DATA, byte_t'($urandom), $urandom_range(0, 7) == 0,
							byte_t'($urandom), 1'b0, 8'h00);
				end
				offer_item(CMD_KEY, byte_t'($urandom), k == klen - 1, byte_t'($urandom),
					1'b0, 8'h00);
			end
			ndata = $urandom_range(1, 40);
			for (d = 0; d < ndata; d++)
				offer_item(CMD_DATA, byte_t'($urandom), $urandom_range(0, 7) == 0,
					byte_t'($urandom), 1'b0, 8'h00);
			seq = seq + 1;
		end
		s_axis_tvalid <= 1'b0;

		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rc4_pkg.sv
rtl/rc4_sbox_ram.sv
rtl/rc4_key_store.sv
rtl/rc4_stream_cipher_core.sv
test/rc4_stream_cipher_core_tb.sv
